@@ hdl/jawf_pkg.sv @@
// Shared constants and types for the JSON argument wrapper filter.
package jawf_pkg;

    localparam int PREFIX_LIMIT_DEF = 100;
    localparam int DEPTH_BITS_DEF   = 16;
    localparam int OUT_BYTES_DEF    = 8;

    // Fixed result layout: eight byte lanes and a four-bit count.
    localparam int OUT_LANES = 8;
    localparam int COUNT_W   = 4;

    localparam int MARK_LEN = 12;

    // The quoted arguments key followed by its colon.
    localparam logic [7:0] ARG_MARKER [MARK_LEN] = '{
        8'h22, 8'h61, 8'h72, 8'h67, 8'h75, 8'h6d,
        8'h65, 8'h6e, 8'h74, 8'h73, 8'h22, 8'h3a
    };

    localparam logic [7:0] CHAR_OPEN  = 8'h7b;
    localparam logic [7:0] CHAR_CLOSE = 8'h7d;

    localparam logic OP_NEW_TASK = 1'b0;
    localparam logic OP_CHAR     = 1'b1;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_STREAM = 4'b0010,
        PH_FLUSH  = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

endpackage

@@ hdl/jawf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module jawf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/json_argument_wrapper_filter.sv @@
// Top level of the JSON argument wrapper filter.
//
// The block takes one text byte per cycle when not stalled. Until the quoted arguments key
// and its colon have been seen, bytes are held in a prefix buffer: full groups of OUT_BYTES
// bytes sit in a RAM, the group being filled sits in a staging register. Once the key is
// seen the buffer is dropped and later bytes pass through one per result, with brace depth
// tracked until a closing brace brings it back to zero; a closing brace at depth zero is
// dropped and also ends the run. If PREFIX_LIMIT+1 bytes gather without the key, the
// request that overflows the buffer stalls the input while the buffer is sent out through
// the RAM's single read port, one group per cycle while the output is free. Other requests
// cause no stall of their own. While streaming, a request is taken only in a cycle in which
// the output register is empty or its result is taken at the same edge; while skipping or
// done, a request is taken even while a result waits. An opcode of zero starts a new task,
// clearing phase, counters, depth and marker window; the buffer RAM needs no clearing pass.
module json_argument_wrapper_filter #(
    parameter int PREFIX_LIMIT = jawf_pkg::PREFIX_LIMIT_DEF,
    parameter int DEPTH_BITS   = jawf_pkg::DEPTH_BITS_DEF,
    parameter int OUT_BYTES    = jawf_pkg::OUT_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_byte_0..out_byte_7 in [63:0], byte_count [67:64]
    output logic        m_tlast    // last_of_run
);

    localparam int ROWS    = PREFIX_LIMIT / OUT_BYTES;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_CW  = $clog2(ROWS + 1);
    localparam int LANE_W  = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
    localparam int FILL_W  = $clog2(PREFIX_LIMIT + 1);
    localparam int TALLY_W = $clog2(PREFIX_LIMIT + 2) + 1;
    localparam int CW      = (TALLY_W > DEPTH_BITS) ? TALLY_W : DEPTH_BITS;
    localparam int NL      = jawf_pkg::OUT_LANES;
    localparam int CNT_W   = jawf_pkg::COUNT_W;
    localparam int ML      = jawf_pkg::MARK_LEN;

    localparam logic signed [DEPTH_BITS-1:0] D_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] D_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [CW-1:0] D_MAX_EXT = CW'(D_MAX);
    localparam logic signed [CW-1:0] D_MIN_EXT = CW'(D_MIN);

    jawf_pkg::phase_t phase_reg, phase_next;

    logic [7:0]                    window_reg [ML];
    logic [7:0]                    window_next [ML];
    logic [7:0]                    window_next_q [ML];
    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic signed [TALLY_W-1:0]     tally_reg, tally_next, tally_inc;
    logic signed [CW-1:0]          tally_ext;
    logic signed [DEPTH_BITS-1:0]  depth_reg, depth_next, depth_load;
    logic [ROW_CW-1:0]             row_reg, row_next;
    logic [LANE_W-1:0]             lane_reg, lane_next;
    logic [ROW_CW-1:0]             fl_row_reg, fl_row_next;
    logic [OUT_BYTES-1:0][7:0]     stage_reg, stage_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [NL-1:0][7:0]            out_bytes_reg, out_bytes_next;
    logic [CNT_W-1:0]              out_count_reg, out_count_next;
    logic                          out_last_reg, out_last_next;

    logic                          in_accept;
    logic                          out_free;
    logic [7:0]                    c;
    logic                          marker_hit;
    logic [ML-1:0]                 marker_eq;

    logic                          ram_we;
    logic [OUT_BYTES-1:0][7:0]     ram_wdata;
    logic [OUT_BYTES-1:0][7:0]     ram_rdata;
    logic [NL-1:0][7:0]            ram_group;
    logic [NL-1:0][7:0]            stage_group;

    assign c         = s_tdata;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (phase_reg != jawf_pkg::PH_FLUSH) &&
                       (out_free || phase_reg != jawf_pkg::PH_STREAM);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_count_reg, out_bytes_reg};
    assign m_tlast  = out_last_reg;

    // Marker compare on the window as it stands after this byte is shifted in.
    always_comb begin
        for (int i = 0; i < ML; i++) begin
            window_next[i] = (i < ML - 1) ? window_reg[(i + 1) % ML] : c;
            marker_eq[i]   = (window_next[i] == jawf_pkg::ARG_MARKER[i]);
        end
    end
    assign marker_hit = &marker_eq;

    always_comb begin
        tally_inc = tally_reg;
        if (c == jawf_pkg::CHAR_OPEN) begin
            tally_inc = tally_reg + TALLY_W'(1);
        end else if (c == jawf_pkg::CHAR_CLOSE) begin
            tally_inc = tally_reg - TALLY_W'(1);
        end
    end

    assign tally_ext = CW'(tally_inc);

    always_comb begin
        if (tally_ext > D_MAX_EXT) begin
            depth_load = D_MAX;
        end else if (tally_ext < D_MIN_EXT) begin
            depth_load = D_MIN;
        end else begin
            depth_load = DEPTH_BITS'(tally_ext);
        end
    end

    // Row being written: the staged bytes with the incoming byte in its lane.
    always_comb begin
        ram_wdata = stage_reg;
        ram_wdata[lane_reg] = c;
    end

    for (genvar gk = 0; gk < NL; gk++) begin : g_lane
        if (gk < OUT_BYTES) begin : g_used
            assign ram_group[gk]   = ram_rdata[gk];
            assign stage_group[gk] = (lane_reg >= LANE_W'(gk)) ? stage_reg[gk] : 8'h00;
        end else begin : g_unused
            assign ram_group[gk]   = 8'h00;
            assign stage_group[gk] = 8'h00;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        tally_next     = tally_reg;
        depth_next     = depth_reg;
        row_next       = row_reg;
        lane_next      = lane_reg;
        fl_row_next    = fl_row_reg;
        stage_next     = stage_reg;
        ram_we         = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_bytes_next = out_bytes_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        for (int i = 0; i < ML; i++) begin
            window_next_q[i] = window_reg[i];
        end

        if (phase_reg == jawf_pkg::PH_FLUSH) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
                if (fl_row_reg == row_reg) begin
                    // The staged group closes the flush.
                    out_bytes_next = stage_group;
                    out_count_next = CNT_W'(lane_reg) + CNT_W'(1);
                    out_last_next  = 1'b1;
                    phase_next     = jawf_pkg::PH_STREAM;
                    row_next       = '0;
                    lane_next      = '0;
                end else begin
                    out_bytes_next = ram_group;
                    out_count_next = CNT_W'(OUT_BYTES);
                    out_last_next  = 1'b0;
                    fl_row_next    = fl_row_reg + ROW_CW'(1);
                end
            end
        end else if (in_accept) begin
            if (s_tuser == jawf_pkg::OP_NEW_TASK) begin
                phase_next = jawf_pkg::PH_SKIP;
                fill_next  = '0;
                tally_next = '0;
                depth_next = '0;
                row_next   = '0;
                lane_next  = '0;
                for (int i = 0; i < ML; i++) begin
                    window_next_q[i] = 8'h00;
                end
            end else begin
                case (phase_reg)
                    jawf_pkg::PH_SKIP: begin
                        for (int i = 0; i < ML; i++) begin
                            window_next_q[i] = window_next[i];
                        end
                        if (marker_hit) begin
                            phase_next = jawf_pkg::PH_STREAM;
                            fill_next  = '0;
                            tally_next = '0;
                            depth_next = '0;
                            row_next   = '0;
                            lane_next  = '0;
                        end else if (fill_reg == FILL_W'(PREFIX_LIMIT)) begin
                            stage_next[lane_reg] = c;
                            phase_next  = jawf_pkg::PH_FLUSH;
                            fl_row_next = '0;
                            depth_next  = depth_load;
                            fill_next   = '0;
                            tally_next  = '0;
                        end else begin
                            fill_next  = fill_reg + FILL_W'(1);
                            tally_next = tally_inc;
                            stage_next[lane_reg] = c;
                            if (lane_reg == LANE_W'(OUT_BYTES - 1)) begin
                                ram_we    = 1'b1;
                                lane_next = '0;
                                row_next  = row_reg + ROW_CW'(1);
                            end else begin
                                lane_next = lane_reg + LANE_W'(1);
                            end
                        end
                    end
                    jawf_pkg::PH_STREAM: begin
                        out_bytes_next    = '0;
                        out_bytes_next[0] = c;
                        out_count_next    = CNT_W'(1);
                        out_last_next     = 1'b1;
                        if (c == jawf_pkg::CHAR_OPEN) begin
                            m_tvalid_next = 1'b1;
                            if (depth_reg != D_MAX) begin
                                depth_next = depth_reg + DEPTH_BITS'(1);
                            end
                        end else if (c == jawf_pkg::CHAR_CLOSE) begin
                            if (depth_reg > 0) begin
                                m_tvalid_next = 1'b1;
                                depth_next    = depth_reg - DEPTH_BITS'(1);
                                if (depth_reg == DEPTH_BITS'(1)) begin
                                    phase_next = jawf_pkg::PH_DONE;
                                end
                            end else if (depth_reg == '0) begin
                                phase_next = jawf_pkg::PH_DONE;
                            end
                        end else begin
                            m_tvalid_next = 1'b1;
                        end
                    end
                    default: begin
                        // Done: bytes are dropped.
                    end
                endcase
            end
        end
    end

    jawf_ram #(
        .WIDTH (8 * OUT_BYTES),
        .DEPTH (ROWS),
        .ADDR_W(ROW_AW)
    ) u_prefix_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(row_reg[ROW_AW-1:0]),
        .wr_data(ram_wdata),
        .rd_addr(fl_row_next[ROW_AW-1:0]),
        .rd_data(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= jawf_pkg::PH_SKIP;
            fill_reg     <= '0;
            tally_reg    <= '0;
            depth_reg    <= '0;
            row_reg      <= '0;
            lane_reg     <= '0;
            fl_row_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < ML; i++) begin
                window_reg[i] <= 8'h00;
            end
        end else begin
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            tally_reg    <= tally_next;
            depth_reg    <= depth_next;
            row_reg      <= row_next;
            lane_reg     <= lane_next;
            fl_row_reg   <= fl_row_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int i = 0; i < ML; i++) begin
                window_reg[i] <= window_next_q[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg     <= stage_next;
        out_bytes_reg <= out_bytes_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

`ifndef SYNTHESIS
    // While skipping, the staged lane and the written rows account for every buffered byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == jawf_pkg::PH_SKIP) |->
            (32'(fill_reg) == 32'(row_reg) * OUT_BYTES + 32'(lane_reg)))
        else $error("prefix fill out of step with row and lane");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == jawf_pkg::PH_FLUSH) |-> (fl_row_reg <= row_reg))
        else $error("flush read ran past the written rows");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[67:64] != '0) && (32'(m_tdata[67:64]) <= OUT_BYTES))
        else $error("result byte count out of range");
`endif

endmodule
